### rtl/dds_multi_waveform_generator_macros.svh
`ifndef DDS_MULTI_WAVEFORM_GENERATOR_MACROS_SVH
`define DDS_MULTI_WAVEFORM_GENERATOR_MACROS_SVH

// condition must hold in the same cycle
`define DDS_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the next cycle
`define DDS_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dds_mwg_pkg.sv
package dds_mwg_pkg;

  // fixed field widths
  localparam int AMP_BITS   = 16;
  localparam int OUT_W      = AMP_BITS + 1;
  localparam int STEP_W     = 32;
  localparam int PHASE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = CFG_IDX_W'(2);

  // parameter defaults
  localparam int ACC_BITS_DEF      = 32;
  localparam int LUT_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF   = 16;

  // quarter-wave table generation
  localparam logic [63:0] HALFPI_Q30   = 64'd1686629713;
  localparam int          TAYLOR_TERMS = 12;

  // control of the phase stage toward the wave stage
  typedef struct packed {
    logic valid;
    logic clamped;
  } stg_ctl_t;

  // one quarter-wave entry: round(sin(pi/2*q/2^(lut_bits-2)) * 2^(sample_bits-1))
  function automatic logic [31:0] rom_entry(input int q, input int lut_bits,
                                            input int sample_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] one;
    logic [63:0] v;
    longint      sum;
    x    = (HALFPI_Q30 * 64'(q)) >> (lut_bits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    one = 64'd1 << (sample_bits - 1);
    v   = (64'(sum) * one + (64'd1 << 29)) >> 30;
    if (v > one - 64'd1) begin
      v = one - 64'd1;
    end
    return v[31:0];
  endfunction

endpackage

### rtl/dds_mwg_in_if.sv
interface dds_mwg_in_if;
  logic valid;
  logic ready;
  logic reset_phase;

  modport source(output valid, output reset_phase, input ready);
  modport sink(input valid, input reset_phase, output ready);
endinterface

### rtl/dds_mwg_out_if.sv
interface dds_mwg_out_if;
  import dds_mwg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [PHASE_W-1:0]      phase;
  logic signed [OUT_W-1:0] square_out;
  logic signed [OUT_W-1:0] triangle_out;
  logic signed [OUT_W-1:0] sine_out;
  logic signed [OUT_W-1:0] cosine_out;
  logic                    step_clamped;

  modport source(output valid, output phase, output square_out, output triangle_out,
                 output sine_out, output cosine_out, output step_clamped, input ready);
  modport sink(input valid, input phase, input square_out, input triangle_out,
               input sine_out, input cosine_out, input step_clamped, output ready);
endinterface

### rtl/dds_mwg_cfg_if.sv
interface dds_mwg_cfg_if;
  import dds_mwg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/dds_multi_waveform_generator.sv
// channel   dir  beat contents
// in_ch     in   reset_phase
// out_ch    out  phase, square_out, triangle_out, sine_out, cosine_out, step_clamped
// cfg_ch    in   index, data (phase_step, amplitude, offset)
//
// one beat per clock unless out_ch stalls; beats pass the phase, then output register
// the phase add is the only feedback, all waveforms come from one logic pass
// between the phase register and the output register
// rst_n clears the accumulator, the configuration registers and both valid flags
// a stalled output holds its beat; the input side keeps taking beats while the
// phase stage is empty or moving on
`include "dds_multi_waveform_generator_macros.svh"

module dds_multi_waveform_generator #(
  parameter int ACC_BITS      = dds_mwg_pkg::ACC_BITS_DEF,
  parameter int LUT_ADDR_BITS = dds_mwg_pkg::LUT_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS   = dds_mwg_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  dds_mwg_in_if.sink    in_ch,
  dds_mwg_out_if.source out_ch,
  dds_mwg_cfg_if.sink   cfg_ch
);
  import dds_mwg_pkg::*;

  logic [STEP_W-1:0]          step_r, step_nxt;
  logic signed [AMP_BITS-1:0] amp_r, amp_nxt;
  logic signed [AMP_BITS-1:0] off_r, off_nxt;
  logic [ACC_BITS-1:0]        acc;
  stg_ctl_t                   stg;
  logic                       stg_rdy;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    step_nxt = step_r;
    amp_nxt  = amp_r;
    off_nxt  = off_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PHASE_STEP: step_nxt = cfg_ch.data[STEP_W-1:0];
        REG_AMPLITUDE:  amp_nxt  = $signed(cfg_ch.data[AMP_BITS-1:0]);
        REG_OFFSET:     off_nxt  = $signed(cfg_ch.data[AMP_BITS-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      amp_r  <= '0;
      off_r  <= '0;
    end else begin
      step_r <= step_nxt;
      amp_r  <= amp_nxt;
      off_r  <= off_nxt;
    end
  end

  // phase accumulator stage
  dds_mwg_phase #(
    .ACC_BITS(ACC_BITS)
  ) u_phase (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .step   (step_r),
    .stg_rdy(stg_rdy),
    .acc    (acc),
    .stg    (stg)
  );

  // waveform logic and output register
  dds_mwg_wave #(
    .ACC_BITS     (ACC_BITS),
    .LUT_ADDR_BITS(LUT_ADDR_BITS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_wave (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .stg    (stg),
    .amp    (amp_r),
    .off    (off_r),
    .stg_rdy(stg_rdy),
    .out_ch (out_ch)
  );

  // checks
  `DDS_ASSERT_NEXT(a_phase_clear, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.reset_phase, acc == '0, "phase not cleared after reset beat")
  `DDS_ASSERT_NEXT(a_stage_moves, clk, rst_n, stg.valid && stg_rdy, out_ch.valid, "phase stage beat lost")
  `DDS_ASSERT_NEXT(a_no_extra, clk, rst_n, out_ch.valid && out_ch.ready && !stg.valid, !out_ch.valid, "result without a source beat")

endmodule

### rtl/dds_mwg_phase.sv
module dds_mwg_phase #(
  parameter int ACC_BITS = dds_mwg_pkg::ACC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  dds_mwg_in_if.sink                       in_ch,
  input  logic [dds_mwg_pkg::STEP_W-1:0]   step,
  input  logic                             stg_rdy,
  output logic [ACC_BITS-1:0]              acc,
  output dds_mwg_pkg::stg_ctl_t            stg
);
  import dds_mwg_pkg::*;

  localparam int CMP_W = (ACC_BITS > STEP_W) ? ACC_BITS : STEP_W;
  localparam logic [CMP_W-1:0] QUARTER = CMP_W'(1) << (ACC_BITS - 2);

  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  stg_ctl_t            stg_r, stg_nxt;
  logic [CMP_W-1:0]    step_ext;
  logic                over;
  logic [ACC_BITS-1:0] step_use;
  logic                accept;

  // limit the step to a quarter cycle
  assign step_ext = CMP_W'(step);
  assign over     = step_ext > QUARTER;
  assign step_use = over ? ACC_BITS'(QUARTER) : ACC_BITS'(step_ext);

  // stage accepts when empty or when its beat moves on
  assign in_ch.ready = !stg_r.valid || stg_rdy;
  assign accept      = in_ch.valid && in_ch.ready;

  // accumulator and stage control
  always_comb begin
    acc_nxt = acc_r;
    stg_nxt = stg_r;
    if (accept) begin
      acc_nxt       = in_ch.reset_phase ? '0 : acc_r + step_use;
      stg_nxt.valid = 1'b1;
      stg_nxt.clamped = over;
    end else if (stg_rdy) begin
      stg_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      stg_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      stg_r <= stg_nxt;
    end
  end

  assign acc = acc_r;
  assign stg = stg_r;

endmodule

### rtl/dds_mwg_wave.sv
module dds_mwg_wave #(
  parameter int ACC_BITS      = dds_mwg_pkg::ACC_BITS_DEF,
  parameter int LUT_ADDR_BITS = dds_mwg_pkg::LUT_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS   = dds_mwg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [ACC_BITS-1:0]                    acc,
  input  dds_mwg_pkg::stg_ctl_t                  stg,
  input  logic signed [dds_mwg_pkg::AMP_BITS-1:0] amp,
  input  logic signed [dds_mwg_pkg::AMP_BITS-1:0] off,
  output logic                                   stg_rdy,
  dds_mwg_out_if.source                          out_ch
);
  import dds_mwg_pkg::*;

  localparam int QW       = LUT_ADDR_BITS - 2;
  localparam int QTR      = 1 << QW;
  localparam int PROD_T_W = AMP_BITS + 33;
  localparam int PROD_S_W = AMP_BITS + SAMPLE_BITS;
  localparam int SUM_W    = OUT_W + 1;
  localparam logic [SAMPLE_BITS-1:0] PEAK =
    SAMPLE_BITS'(rom_entry(QTR, LUT_ADDR_BITS, SAMPLE_BITS));

  logic [SAMPLE_BITS-1:0]      rom_w [QTR];
  logic [PHASE_W-1:0]          p32, phase_lo;
  logic signed [SUM_W-1:0]     off_x;
  logic                        above_half, p_above;
  logic signed [OUT_W-1:0]     sq;
  logic signed [32:0]          tri_n;
  logic signed [PROD_T_W-1:0]  tri_prod, tri_bias, tri_quo;
  logic signed [SUM_W-1:0]     tri_sum;
  logic signed [SUM_W-1:0]     lane_sum [2];
  logic                        take;

  logic                        out_valid_r, out_valid_nxt;
  logic [PHASE_W-1:0]          phase_r;
  logic signed [OUT_W-1:0]     sq_r, tri_r, sin_r, cos_r;
  logic                        clamp_r;

  // quarter-wave table, constant
  for (genvar g = 0; g < QTR; g++) begin : g_rom
    localparam logic [SAMPLE_BITS-1:0] VAL = SAMPLE_BITS'(rom_entry(g, LUT_ADDR_BITS,
                                                                    SAMPLE_BITS));
    assign rom_w[g] = VAL;
  end

  // top 32 phase bits and the low 32 bits shown as phase
  if (ACC_BITS >= PHASE_W) begin : g_wide
    assign p32      = acc[ACC_BITS-1 -: PHASE_W];
    assign phase_lo = acc[PHASE_W-1:0];
  end else begin : g_narrow
    assign p32      = {acc, {(PHASE_W - ACC_BITS){1'b0}}};
    assign phase_lo = PHASE_W'(acc);
  end

  assign off_x = $signed({{(SUM_W - AMP_BITS){off[AMP_BITS-1]}}, off});

  // square: strictly above half cycle
  assign above_half = acc[ACC_BITS-1] && (|acc[ACC_BITS-2:0]);
  assign sq = above_half ? ($signed({off[AMP_BITS-1], off}) + $signed({amp[AMP_BITS-1], amp}))
                         : ($signed({off[AMP_BITS-1], off}) - $signed({amp[AMP_BITS-1], amp}));

  // triangle: n in [-2^30, 2^30], scaled and truncated toward zero
  assign p_above  = p32[31] && (|p32[30:0]);
  assign tri_n    = p_above ? (33'sh0C0000000 - $signed({1'b0, p32}))
                            : ($signed({1'b0, p32}) - 33'sh040000000);
  assign tri_prod = amp * tri_n;
  assign tri_bias = $signed({{(PROD_T_W - 30){1'b0}}, {30{tri_prod[PROD_T_W-1]}}});
  assign tri_quo  = (tri_prod + tri_bias) >>> 30;
  assign tri_sum  = $signed(tri_quo[SUM_W-1:0]) + off_x;

  // sine lane and cosine lane, quarter-wave mirrored
  for (genvar k = 0; k < 2; k++) begin : g_lane
    logic [LUT_ADDR_BITS-1:0]   idx;
    logic [1:0]                 quad;
    logic [QW-1:0]              r, r_sel;
    logic                       at_peak;
    logic [SAMPLE_BITS-1:0]     mag;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic signed [PROD_S_W-1:0] prod, bias, quo;

    assign idx     = acc[ACC_BITS-1 -: LUT_ADDR_BITS] + LUT_ADDR_BITS'(k * QTR);
    assign quad    = idx[LUT_ADDR_BITS-1 -: 2];
    assign r       = idx[QW-1:0];
    assign r_sel   = quad[0] ? (~r + 1'b1) : r;
    assign at_peak = quad[0] && (r == '0);
    assign mag     = at_peak ? PEAK : rom_w[r_sel];
    assign smp     = quad[1] ? -$signed(mag) : $signed(mag);
    assign prod    = amp * smp;
    assign bias    = $signed({{(PROD_S_W - SAMPLE_BITS + 1){1'b0}},
                              {(SAMPLE_BITS - 1){prod[PROD_S_W-1]}}});
    assign quo     = (prod + bias) >>> (SAMPLE_BITS - 1);
    assign lane_sum[k] = $signed(quo[SUM_W-1:0]) + off_x;
  end

  // output register handshake
  assign stg_rdy = !out_valid_r || out_ch.ready;
  assign take    = stg.valid && stg_rdy;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      phase_r <= phase_lo;
      sq_r    <= sq;
      tri_r   <= tri_sum[OUT_W-1:0];
      sin_r   <= lane_sum[0][OUT_W-1:0];
      cos_r   <= lane_sum[1][OUT_W-1:0];
      clamp_r <= stg.clamped;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.phase        = phase_r;
  assign out_ch.square_out   = sq_r;
  assign out_ch.triangle_out = tri_r;
  assign out_ch.sine_out     = sin_r;
  assign out_ch.cosine_out   = cos_r;
  assign out_ch.step_clamped = clamp_r;

endmodule
